// File: src/id3v2_tag_frame_parser_assert.svh
// Assertion macros for the tag parser
`ifndef ID3V2_TAG_FRAME_PARSER_ASSERT_SVH
`define ID3V2_TAG_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define ID3P_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ID3P_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);

`endif

// File: src/id3p_pkg.sv
// Constants shared by the tag parser: status codes, frame kinds, tag marks, limits, frame id lookup
`default_nettype none
package id3p_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_TAG    = 3'd1;
  localparam logic [2:0] ST_UNSUPP    = 3'd2;
  localparam logic [2:0] ST_BAD_HDR   = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_OVERRUN   = 3'd5;
  localparam logic [2:0] ST_FRAME_BIG = 3'd6;

  localparam logic [2:0] KIND_ARTIST = 3'd0;
  localparam logic [2:0] KIND_BAND   = 3'd1;
  localparam logic [2:0] KIND_TRACK  = 3'd2;
  localparam logic [2:0] KIND_TITLE  = 3'd3;
  localparam logic [2:0] KIND_ALBUM  = 3'd4;
  localparam logic [2:0] KIND_VENDOR = 3'd5;
  localparam logic [2:0] KIND_NONE   = 3'd7;

  localparam logic [7:0] MARK_0 = 8'h49;
  localparam logic [7:0] MARK_1 = 8'h44;
  localparam logic [7:0] MARK_2 = 8'h33;

  localparam logic [27:0] MAX_TAG_RST   = 28'd1000000;
  localparam logic [15:0] MAX_FRAME_RST = 16'd1000;

  localparam logic [0:0] REG_MAX_TAG   = 1'b0;
  localparam logic [0:0] REG_MAX_FRAME = 1'b1;

  function automatic logic [2:0] lookup_kind(input logic [2:0] mv, input logic [31:0] fid);
    logic [2:0] k;
    k = KIND_NONE;
    if (mv == 3'd2) begin
      case (fid[23:0])
        24'h545031: k = KIND_ARTIST;
        24'h545032: k = KIND_BAND;
        24'h54524B: k = KIND_TRACK;
        24'h545432: k = KIND_TITLE;
        24'h54414C: k = KIND_ALBUM;
        24'h54454E: k = KIND_VENDOR;
        default:    k = KIND_NONE;
      endcase
    end else begin
      case (fid)
        32'h54504531: k = KIND_ARTIST;
        32'h54504532: k = KIND_BAND;
        32'h5452434B: k = KIND_TRACK;
        32'h54495432: k = KIND_TITLE;
        32'h54414C42: k = KIND_ALBUM;
        default:      k = KIND_NONE;
      endcase
    end
    return k;
  endfunction
endpackage
`default_nettype wire

// File: src/id3v2_tag_frame_parser.sv
// ID3v2 tag parser top level: header check, frame walk, text payload out
//
// Input: one file byte per request on in_*; in_tuser marks the first byte
// of a file and restarts the parser. Output: one request per payload byte
// of an artist, band, track, title, album or (v2.2 only) vendor frame (tuser bit 0 low,
// frame kind in tuser[3:1], tlast on the frame's last byte), and one status
// request per file (tuser bit 0 high) carrying the status code and the
// leading tag size. Bytes after the status are ignored until the next
// first byte.
// Each byte is decoded in the cycle it is taken; its result is in the
// output register on the next cycle. One byte per cycle is sustained
// while results are taken; in_tready follows out_tready combinationally
// and drops only while a held result is not taken.
// Reset (rst_n low, synchronous) returns the parser to header state and
// loads the size limits with their defaults. cfg_* writes the limits:
// index 0 largest tag body, index 1 largest wanted frame.
`default_nettype none
module id3v2_tag_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // first_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // payload_byte, status_code, leading_bytes
  output logic [3:0]       out_tuser,  // item_kind, frame_kind
  output logic             out_tlast,  // frame_last
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [27:0] cfg_wdata
);
  import id3p_pkg::*;

  typedef enum logic [3:0] {
    PH_HEAD, PH_EXT, PH_FID, PH_FSIZE, PH_FFLAGS, PH_PAYLOAD, PH_SKIP, PH_PEND, PH_IDLE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [2:0]  mv_r, mv_nxt;
  logic        us_r, us_nxt, ft_r, ft_nxt, ex_r, ex_nxt;
  logic [27:0] tb_r, tb_nxt;
  logic [28:0] tp_r, tp_nxt;
  logic [31:0] fid_r, fid_nxt, fb_r, fb_nxt, bl_r, bl_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic [2:0]  wk_r, wk_nxt;
  logic [3:0]  hf_r, hf_nxt;
  logic [2:0]  sh_r, sh_nxt;
  logic [27:0] max_tag_r;
  logic [15:0] max_frame_r;

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [3:0]  out_user_r;
  logic        out_last_r;

  logic        o_v, o_last, closing, do_top, do_body, done, acc;
  logic [2:0]  o_fk, o_st, idlen;
  logic [7:0]  o_pb, b;
  logic [28:0] o_lead, r;
  logic        o_kind;

  function automatic logic [28:0] rem(input logic [28:0] p, input logic [27:0] t);
    return (p >= {1'b0, t}) ? 29'd0 : ({1'b0, t} - p);
  endfunction

  function automatic logic [28:0] lead(input logic [3:0] hf, input logic [27:0] t,
                                       input logic f);
    logic [28:0] l;
    l = 29'd0;
    if ((hf & 4'hD) == 4'h0) l = {1'b0, t} + 29'd10 + (f ? 29'd10 : 29'd0);
    return l;
  endfunction

  assign acc       = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    phase_nxt = phase_r; fc_nxt = fc_r; mv_nxt = mv_r; us_nxt = us_r; ft_nxt = ft_r;
    ex_nxt = ex_r; tb_nxt = tb_r; tp_nxt = tp_r; fid_nxt = fid_r; fb_nxt = fb_r;
    bl_nxt = bl_r; pb_nxt = pb_r; wk_nxt = wk_r; hf_nxt = hf_r; sh_nxt = sh_r;
    o_v = 1'b0; o_kind = 1'b0; o_fk = 3'd0; o_pb = 8'd0; o_last = 1'b0;
    o_st = 3'd0; o_lead = 29'd0;
    closing = 1'b0; do_top = 1'b0; do_body = 1'b0; done = 1'b0;
    b = in_tdata; r = 29'd0; idlen = 3'd4;
    if (in_tuser) begin
      if (phase_r == PH_PEND) begin
        o_v = 1'b1; o_kind = 1'b1; o_st = sh_r; o_lead = lead(hf_r, tb_r, ft_r);
      end
      phase_nxt = PH_HEAD; fc_nxt = 4'd0; mv_nxt = 3'd0; us_nxt = 1'b0; ft_nxt = 1'b0;
      ex_nxt = 1'b0; tb_nxt = 28'd0; tp_nxt = 29'd0; fid_nxt = 32'd0; fb_nxt = 32'd0;
      bl_nxt = 32'd0; pb_nxt = 8'd0; wk_nxt = 3'd0; hf_nxt = 4'd0; sh_nxt = 3'd0;
    end else if (phase_r == PH_PEND) begin
      o_v = 1'b1; o_kind = 1'b1; o_st = sh_r; o_lead = lead(hf_r, tb_r, ft_r);
      phase_nxt = PH_IDLE;
      done = 1'b1;
    end
    idlen = (mv_nxt == 3'd2) ? 3'd3 : 3'd4;
    if (!done) begin
      if (phase_nxt == PH_HEAD) begin
        if (fc_nxt == 4'd0 && b != MARK_0) hf_nxt[0] = 1'b1;
        if (fc_nxt == 4'd1 && b != MARK_1) hf_nxt[0] = 1'b1;
        if (fc_nxt == 4'd2 && b != MARK_2) hf_nxt[0] = 1'b1;
        if (fc_nxt == 4'd3) begin
          mv_nxt = b[2:0];
          if (b < 8'd2 || b > 8'd4) hf_nxt[1] = 1'b1;
        end
        if (fc_nxt == 4'd5) begin
          us_nxt = b[7]; ex_nxt = b[6]; ft_nxt = b[4];
          if (b[3:0] != 4'd0) hf_nxt[2] = 1'b1;
        end
        if (fc_nxt >= 4'd6) begin
          if (b[7]) hf_nxt[3] = 1'b1;
          tb_nxt = {tb_nxt[20:0], b[6:0]};
        end
        if (fc_nxt == 4'd9) begin
          if (hf_nxt[0]) begin
            sh_nxt = ST_NO_TAG; closing = 1'b1;
          end else if (hf_nxt[2:1] != 2'd0) begin
            sh_nxt = ST_UNSUPP; closing = 1'b1;
          end else if (hf_nxt[3]) begin
            sh_nxt = ST_BAD_HDR; closing = 1'b1;
          end else if (tb_nxt > max_tag_r) begin
            sh_nxt = ST_TOO_LARGE; closing = 1'b1;
          end else begin
            tp_nxt = 29'd0;
            if (ex_nxt) begin
              if (tb_nxt < 28'd6) begin
                sh_nxt = ST_OVERRUN; closing = 1'b1;
              end else begin
                phase_nxt = PH_EXT; fb_nxt = 32'd0; fid_nxt = 32'd0;
              end
            end else begin
              do_top = 1'b1;
            end
          end
        end
        fc_nxt = (phase_nxt == PH_EXT) ? 4'd0 : fc_nxt + 4'd1;
      end else if (phase_nxt != PH_IDLE) begin
        tp_nxt = tp_nxt + 29'd1;
        r = rem(tp_nxt, tb_nxt);
        case (phase_nxt)
          PH_EXT: begin
            if (fc_nxt < 4'd4) begin
              fb_nxt = {fb_nxt[23:0], b};
              if (fc_nxt == 4'd3 && fb_nxt > {4'd0, tb_nxt}) begin
                sh_nxt = ST_OVERRUN; closing = 1'b1;
              end
            end else if (fc_nxt < 4'd6) begin
              fid_nxt = {16'd0, fid_nxt[7:0], b};
            end else if (fc_nxt == 4'd9) begin
              if (fid_nxt[15] && fb_nxt != 32'd10) begin
                sh_nxt = ST_BAD_HDR; closing = 1'b1;
              end else if (!fid_nxt[15]) begin
                do_top = 1'b1;
              end
            end else if (fc_nxt >= 4'd13) begin
              do_top = 1'b1;
            end
            if (!closing && !do_top && tp_nxt >= {1'b0, tb_nxt}) begin
              sh_nxt = ST_OVERRUN; closing = 1'b1;
            end
            fc_nxt = fc_nxt + 4'd1;
          end
          PH_FID: begin
            fid_nxt = {fid_nxt[23:0], b};
            fc_nxt = fc_nxt + 4'd1;
            if (fc_nxt >= {1'b0, idlen}) begin
              if (mv_nxt == 3'd2) begin
                if (r <= 29'd3) begin
                  sh_nxt = ST_OK; closing = 1'b1;
                end
              end else if (r <= 29'd4) begin
                sh_nxt = ST_OVERRUN; closing = 1'b1;
              end
              if (!closing) begin
                phase_nxt = PH_FSIZE; fc_nxt = 4'd0; fb_nxt = 32'd0;
              end
            end
          end
          PH_FSIZE: begin
            fb_nxt = {fb_nxt[23:0], b};
            fc_nxt = fc_nxt + 4'd1;
            if (fc_nxt >= {1'b0, idlen}) begin
              if (fb_nxt == 32'd0) begin
                sh_nxt = ST_OK; closing = 1'b1;
              end else if (mv_nxt == 3'd2) begin
                if (fb_nxt >= {3'd0, r}) begin
                  sh_nxt = ST_OK; closing = 1'b1;
                end else begin
                  do_body = 1'b1;
                end
              end else if ({1'b0, fb_nxt} + 33'd2 > {4'd0, r}) begin
                sh_nxt = ST_OVERRUN; closing = 1'b1;
              end else begin
                phase_nxt = PH_FFLAGS; fc_nxt = 4'd0;
              end
            end
          end
          PH_FFLAGS: begin
            fc_nxt = fc_nxt + 4'd1;
            if (fc_nxt >= 4'd2) do_body = 1'b1;
          end
          PH_PAYLOAD: begin
            if (us_nxt && mv_nxt != 3'd2 && pb_nxt == 8'hFF && b == 8'h00) begin
              pb_nxt = 8'd0;
            end else begin
              pb_nxt = b;
              bl_nxt = bl_nxt - 32'd1;
              o_v = 1'b1; o_kind = 1'b0; o_fk = wk_nxt; o_pb = b;
              o_last = (bl_nxt == 32'd0);
            end
            if (bl_nxt == 32'd0) begin
              do_top = 1'b1;
            end else if (tp_nxt >= {1'b0, tb_nxt}) begin
              sh_nxt = ST_OVERRUN; closing = 1'b1;
            end
          end
          PH_SKIP: begin
            bl_nxt = bl_nxt - 32'd1;
            if (bl_nxt == 32'd0) do_top = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (do_body) begin
        bl_nxt = fb_nxt;
        wk_nxt = lookup_kind(mv_nxt, fid_nxt);
        pb_nxt = 8'd0;
        phase_nxt = PH_SKIP;
        if (wk_nxt != KIND_NONE) begin
          if (mv_nxt == 3'd2) begin
            if (wk_nxt == KIND_VENDOR || fb_nxt <= {16'd0, max_frame_r})
              phase_nxt = PH_PAYLOAD;
          end else if (fb_nxt > {16'd0, max_frame_r}) begin
            sh_nxt = ST_FRAME_BIG; closing = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      if (do_top) begin
        if (rem(tp_nxt, tb_nxt) < 29'd4) begin
          sh_nxt = ST_OK; closing = 1'b1;
        end else begin
          phase_nxt = PH_FID; fc_nxt = 4'd0; fid_nxt = 32'd0;
        end
      end
      if (closing) begin
        if (!o_v) begin
          o_v = 1'b1; o_kind = 1'b1; o_st = sh_nxt; o_lead = lead(hf_nxt, tb_nxt, ft_nxt);
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_PEND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD; fc_r <= 4'd0; mv_r <= 3'd0; us_r <= 1'b0; ft_r <= 1'b0;
      ex_r <= 1'b0; tb_r <= 28'd0; tp_r <= 29'd0; fid_r <= 32'd0; fb_r <= 32'd0;
      bl_r <= 32'd0; pb_r <= 8'd0; wk_r <= 3'd0; hf_r <= 4'd0; sh_r <= 3'd0;
      max_tag_r <= MAX_TAG_RST; max_frame_r <= MAX_FRAME_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MAX_TAG:   max_tag_r <= cfg_wdata;
          REG_MAX_FRAME: max_frame_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        phase_r <= phase_nxt; fc_r <= fc_nxt; mv_r <= mv_nxt; us_r <= us_nxt;
        ft_r <= ft_nxt; ex_r <= ex_nxt; tb_r <= tb_nxt; tp_r <= tp_nxt;
        fid_r <= fid_nxt; fb_r <= fb_nxt; bl_r <= bl_nxt; pb_r <= pb_nxt;
        wk_r <= wk_nxt; hf_r <= hf_nxt; sh_r <= sh_nxt;
        out_valid_r <= o_v;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= {o_lead, o_st, o_pb};
      out_user_r <= {o_fk, o_kind};
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`include "id3v2_tag_frame_parser_assert.svh"

  `ID3P_ASSERT_NXT(a_first_restarts, clk, rst_n, acc && in_tuser, phase_r == PH_HEAD, "restart did not return to header")
  `ID3P_ASSERT_IMP(a_status_no_last, clk, rst_n, out_valid_r && out_user_r[0], !out_last_r && out_user_r[3:1] == 3'd0, "status item carries payload fields")
  `ID3P_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid_r && !out_user_r[0], out_user_r[3:1] <= KIND_VENDOR && out_data_r[39:8] == 32'd0, "bad payload item")
endmodule
`default_nettype wire

// File: bench/id3v2_tag_frame_parser_tb.sv
// Self-checking bench for the ID3v2 tag parser: random and directed files, stream gaps
`timescale 1ns / 100ps
`default_nettype none
module id3v2_tag_frame_parser_tb;
  import id3p_pkg::*;

  localparam int PH_HEAD = 0, PH_EXT = 1, PH_FID = 2, PH_FSIZE = 3, PH_FFLAGS = 4,
                 PH_PAYLOAD = 5, PH_SKIP = 6, PH_PEND = 7, PH_IDLE = 8;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic       item_kind;
    logic [2:0] frame_kind;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic [2:0] status_code;
    logic [28:0] leading_bytes;
  } tag_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = REG_MAX_TAG;
  logic [27:0] cfg_wdata = '0;

  id3v2_tag_frame_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser mirror
  logic [27:0] lim_tag;
  logic [15:0] lim_frame;
  int unsigned ph, fcnt, mver;
  logic unsync, footer, ext;
  logic [27:0] body_len;
  logic [31:0] pos, fid, fsize, left;
  logic [7:0] prev;
  logic [2:0] kind;
  logic [3:0] faults;
  logic [2:0] hold;
  bit closing;

  file_byte_t pending_bytes[$];
  tag_item_t expected_items[$];
  int fails = 0;
  int idle_cycles = 0;

  function automatic logic [3:0] gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 4'd0;
    if (r < 93) return 4'($urandom_range(1, 3));
    return 4'($urandom_range(4, 15));
  endfunction

  task automatic queue_status();
    tag_item_t t;
    t = '0;
    t.item_kind = 1'b1;
    t.status_code = hold;
    if ((faults & 4'hD) == 0) t.leading_bytes = body_len + 29'd10 + (footer ? 29'd10 : 29'd0);
    expected_items.push_back(t);
  endtask

  task automatic clear_parser();
    ph = PH_HEAD; fcnt = 0; mver = 0; unsync = 0; footer = 0; ext = 0; body_len = 0;
    pos = 0; fid = 0; fsize = 0; left = 0; prev = 0; kind = 0; faults = 0; hold = 0;
  endtask

  function automatic logic [31:0] body_remaining();
    return (pos >= body_len) ? 32'd0 : body_len - pos;
  endfunction

  task automatic close_with(input logic [2:0] c);
    hold = c;
    closing = 1;
  endtask

  task automatic next_frame();
    if (body_remaining() < 4) close_with(ST_OK);
    else begin
      ph = PH_FID; fcnt = 0; fid = 0;
    end
  endtask

  function automatic logic [2:0] frame_kind_of();
    if (mver == 2) begin
      case (fid[23:0])
        24'h545031: return KIND_ARTIST;
        24'h545032: return KIND_BAND;
        24'h54524B: return KIND_TRACK;
        24'h545432: return KIND_TITLE;
        24'h54414C: return KIND_ALBUM;
        24'h54454E: return KIND_VENDOR;
        default: return KIND_NONE;
      endcase
    end
    case (fid)
      32'h54504531: return KIND_ARTIST;
      32'h54504532: return KIND_BAND;
      32'h5452434B: return KIND_TRACK;
      32'h54495432: return KIND_TITLE;
      32'h54414C42: return KIND_ALBUM;
      default: return KIND_NONE;
    endcase
  endfunction

  task automatic open_frame_body();
    left = fsize; kind = frame_kind_of(); prev = 0; ph = PH_SKIP;
    if (kind == KIND_NONE) return;
    if (mver == 2) begin
      if (kind == KIND_VENDOR || fsize <= lim_frame) ph = PH_PAYLOAD;
    end else if (fsize > lim_frame) close_with(ST_FRAME_BIG);
    else ph = PH_PAYLOAD;
  endtask

  task automatic header_in(input logic [7:0] b);
    int unsigned idx;
    idx = fcnt;
    if (idx < 3) begin
      if (b != (idx == 0 ? MARK_0 : idx == 1 ? MARK_1 : MARK_2)) faults[0] = 1;
    end else if (idx == 3) begin
      mver = b[2:0];
      if (b < 2 || b > 4) faults[1] = 1;
    end else if (idx == 5) begin
      unsync = b[7]; ext = b[6]; footer = b[4];
      if (b[3:0] != 0) faults[2] = 1;
    end else if (idx >= 6) begin
      if (b[7]) faults[3] = 1;
      body_len = {body_len[20:0], b[6:0]};
    end
    fcnt = idx + 1;
    if (idx != 9) return;
    if (faults[0]) close_with(ST_NO_TAG);
    else if (faults[2:1] != 0) close_with(ST_UNSUPP);
    else if (faults[3]) close_with(ST_BAD_HDR);
    else if (body_len > lim_tag) close_with(ST_TOO_LARGE);
    else begin
      pos = 0;
      if (ext) begin
        if (body_len < 6) close_with(ST_OVERRUN);
        else begin
          ph = PH_EXT; fcnt = 0; fsize = 0; fid = 0;
        end
      end else next_frame();
    end
  endtask

  task automatic ext_in(input logic [7:0] b);
    int unsigned idx;
    idx = fcnt;
    fcnt = (idx + 1) & 15;
    if (idx < 4) begin
      fsize = {fsize[23:0], b};
      if (idx == 3 && fsize > body_len) begin
        close_with(ST_OVERRUN); return;
      end
    end else if (idx < 6) fid = {16'h0, fid[7:0], b};
    else if (idx == 9) begin
      if (fid[15] && fsize != 10) begin
        close_with(ST_BAD_HDR); return;
      end
      if (!fid[15]) begin
        next_frame(); return;
      end
    end else if (idx >= 13) begin
      next_frame(); return;
    end
    if (pos >= body_len) close_with(ST_OVERRUN);
  endtask

  task automatic predict_byte(input file_byte_t fb);
    int unsigned idlen;
    bit emitted;
    tag_item_t t;
    emitted = 0;
    closing = 0;
    if (fb.first_byte) begin
      if (ph == PH_PEND) queue_status();
      clear_parser();
    end else if (ph == PH_PEND) begin
      queue_status();
      ph = PH_IDLE;
      return;
    end
    idlen = (mver == 2) ? 3 : 4;
    if (ph == PH_HEAD) header_in(fb.data_byte);
    else if (ph != PH_IDLE) begin
      pos = pos + 1;
      case (ph)
        PH_EXT: ext_in(fb.data_byte);
        PH_FID: begin
          fid = {fid[23:0], fb.data_byte};
          fcnt++;
          if (fcnt >= idlen) begin
            if (mver == 2) begin
              if (body_remaining() <= 3) close_with(ST_OK);
            end else if (body_remaining() <= 4) close_with(ST_OVERRUN);
            if (!closing) begin
              ph = PH_FSIZE; fcnt = 0; fsize = 0;
            end
          end
        end
        PH_FSIZE: begin
          fsize = {fsize[23:0], fb.data_byte};
          fcnt++;
          if (fcnt >= idlen) begin
            if (fsize == 0) close_with(ST_OK);
            else if (mver == 2) begin
              if (fsize >= body_remaining()) close_with(ST_OK);
              else open_frame_body();
            end else if ({1'b0, fsize} + 33'd2 > {1'b0, body_remaining()})
              close_with(ST_OVERRUN);
            else begin
              ph = PH_FFLAGS; fcnt = 0;
            end
          end
        end
        PH_FFLAGS: begin
          fcnt++;
          if (fcnt >= 2) open_frame_body();
        end
        PH_PAYLOAD: begin
          if (unsync && mver != 2 && prev == 8'hFF && fb.data_byte == 0) prev = 0;
          else begin
            prev = fb.data_byte;
            left--;
            t = '0;
            t.frame_kind = kind;
            t.payload_byte = fb.data_byte;
            t.frame_last = (left == 0);
            expected_items.push_back(t);
            emitted = 1;
          end
          if (left == 0) next_frame();
          else if (pos >= body_len) close_with(ST_OVERRUN);
        end
        PH_SKIP: begin
          left--;
          if (left == 0) next_frame();
        end
        default: ;
      endcase
    end
    if (closing) begin
      if (!emitted) begin
        queue_status(); ph = PH_IDLE;
      end else ph = PH_PEND;
    end
  endtask

  // stimulus building
  task automatic push_byte(input logic [7:0] b, input bit first);
    file_byte_t fb;
    fb.data_byte = b;
    fb.first_byte = first;
    pending_bytes.push_back(fb);
  endtask

  task automatic push_header(input int v, input logic [7:0] flags, input int unsigned sz);
    push_byte(MARK_0, 1'b1); push_byte(MARK_1, 1'b0); push_byte(MARK_2, 1'b0);
    push_byte(v[7:0], 1'b0); push_byte(8'h00, 1'b0); push_byte(flags, 1'b0);
    push_byte({1'b0, 7'(sz >> 21)}, 1'b0); push_byte({1'b0, 7'(sz >> 14)}, 1'b0);
    push_byte({1'b0, 7'(sz >> 7)}, 1'b0); push_byte({1'b0, 7'(sz)}, 1'b0);
  endtask

  function automatic logic [31:0] pick_id(input int v);
    logic [31:0] ids3[6] = '{32'h54504531, 32'h54504532, 32'h5452434B, 32'h54495432,
                              32'h54414C42, 32'h54585858};
    logic [31:0] ids2[7] = '{32'h545031, 32'h545032, 32'h54524B, 32'h545432, 32'h54414C,
                              32'h54454E, 32'h434F4D};
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (v == 2) return ids2[$urandom_range(0, 6)];
    return ids3[$urandom_range(0, 5)];
  endfunction

  task automatic push_tag_file(input int v, input bit sane);
    int unsigned body, nfr, fs, k, sz, pad;
    logic [7:0] flags;
    logic [31:0] id;
    logic [7:0] frame[$];
    logic [7:0] b;
    frame = {};
    flags = {$urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, 1'b0,
             $urandom_range(0, 7) == 0, 4'h0};
    if (!sane && $urandom_range(0, 2) == 0) flags[3:0] = 4'($urandom);
    if (flags[6]) begin
      if ($urandom_range(0, 1)) begin
        frame = {8'h0, 8'h0, 8'h0, 8'd10, 8'h80, 8'h00, 8'h0, 8'h0, 8'h0, 8'h0,
                 8'h11, 8'h22, 8'h33, 8'h44};
      end else frame = {8'h0, 8'h0, 8'h0, 8'd6, 8'h00, 8'h00, 8'h0, 8'h0, 8'h0, 8'h0};
      if (!sane) frame[3] = 8'($urandom_range(0, 20));
    end
    nfr = $urandom_range(1, 4);
    for (int f = 0; f < nfr; f++) begin
      id = pick_id(v);
      fs = $urandom_range(1, 12);
      for (int i = (v == 2 ? 2 : 3); i >= 0; i--) frame.push_back(id[8 * i +: 8]);
      sz = fs;
      for (int i = (v == 2 ? 2 : 3); i >= 0; i--) frame.push_back(sz[8 * i +: 8]);
      if (v != 2) begin
        frame.push_back(8'($urandom)); frame.push_back(8'($urandom));
      end
      for (k = 0; k < fs; k++) begin
        b = ($urandom_range(0, 3) == 0) ? 8'hFF :
            ($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
        frame.push_back(b);
      end
    end
    pad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    for (k = 0; k < pad; k++) frame.push_back(8'h00);
    body = frame.size();
    if (!sane) body = body + $urandom_range(0, 8) - 4;
    push_header(v, flags, body);
    for (k = 0; k < frame.size(); k++) push_byte(frame[k], 1'b0);
    for (k = 0; k < $urandom_range(0, 3); k++) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic set_limit(input logic [0:0] idx, input logic [27:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MAX_TAG) lim_tag = val;
    else lim_frame = val[15:0];
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_byte(pending_bytes.pop_front());
        in_gap = gap_len();
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_bytes[0].data_byte;
          in_tuser <= pending_bytes[0].first_byte;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  tag_item_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.item_kind = out_tuser[0];
        got.frame_kind = out_tuser[3:1];
        got.payload_byte = out_tdata[7:0];
        got.status_code = out_tdata[10:8];
        got.leading_bytes = out_tdata[39:11];
        got.frame_last = out_tlast;
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected request %h", $time, got);
          fails++;
        end else begin
          want = expected_items.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fails++;
          end
        end
      end
      out_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 0);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("id3v2_tag_frame_parser test failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_no;
    lim_tag = MAX_TAG_RST;
    lim_frame = MAX_FRAME_RST;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: each header fault, a good v2/v3/v4 tag, oversize frame
    push_byte(8'h4A, 1'b1); for (int i = 0; i < 9; i++) push_byte(8'h00, 1'b0);
    push_header(5, 8'h00, 20);
    push_header(3, 8'h0F, 20);
    push_header(3, 8'h00, 20); pending_bytes[$-1].data_byte = 8'hFF;
    push_header(4, 8'h00, 28'h0FFFFFFF);
    push_tag_file(2, 1);
    push_tag_file(3, 1);
    push_tag_file(4, 1);
    drain();
    set_limit(REG_MAX_FRAME, 28'd1);
    set_limit(REG_MAX_TAG, 28'd0);
    push_tag_file(3, 1);
    drain();
    set_limit(REG_MAX_TAG, 28'h0FFFFFF);
    push_tag_file(3, 1); push_tag_file(2, 1);
    drain();
    phase_no = 0;
    while (phase_no < 6) begin
      set_limit(REG_MAX_FRAME, phase_no == 5 ? 28'hFFFF : 28'($urandom_range(1, 12)));
      set_limit(REG_MAX_TAG, phase_no == 4 ? 28'h0FFFFFFF : 28'($urandom_range(20, 400)));
      for (int f = 0; f < 6; f++) begin
        push_tag_file($urandom_range(2, 4), $urandom_range(0, 4) != 0);
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom), 1'b1);
      end
      drain();
      phase_no++;
    end
    repeat (20) @(posedge clk);
    if (fails == 0 && expected_items.size() == 0)
      $display("id3v2_tag_frame_parser test passed");
    else
      $display("id3v2_tag_frame_parser test failed");
    $finish;
  end
endmodule
`default_nettype wire
